>>> rtl/lsfo_pkg.sv
// ----------------------------------------------------------------------------
// lsfo_pkg: shared types and constants of the log spectral flux onset block
// Field widths, fixed-point constants, register indexes and the structs that
// travel between the pipeline modules.
// ----------------------------------------------------------------------------
package lsfo_pkg;

   localparam int MAX_BINS_DEF = 4096;

   localparam int MAG_W     = 24;  // unsigned Q16.8 magnitude
   localparam int CFG_W     = 13;  // configuration register width
   localparam int CSR_IDX_W = 4;
   localparam int SUM_W     = 28;  // Q16.12 flux sums
   localparam int LOG_W     = 16;  // Q4.12 compressed magnitude
   localparam int V_W       = 28;  // 1 + 10*m in Q.8
   localparam int Z_W       = 31;  // mantissa in Q1.30
   localparam int FRAC_W    = 16;  // log2 fraction bits, one per squaring round
   localparam int EXP_W     = 5;   // leading-one index
   localparam int LN2_W     = 16;
   localparam int ROUND_SH  = 20;

   localparam logic [LN2_W-1:0] LN2_Q16         = 16'd45426;
   localparam logic [V_W-1:0]   V_ONE           = 28'd256;
   localparam logic [EXP_W-1:0] EXP_BIAS        = 5'd8;
   localparam logic [CFG_W-1:0] NUM_BINS_RST    = 13'd513;
   localparam logic [CFG_W-1:0] LOW_BIN_END_RST = 13'd4;
   localparam logic [SUM_W-1:0] SUM_MAX         = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_BINS    = 4'd0,
      CSR_LOW_BIN_END = 4'd1
   } csr_index_type;

   // Per-item control that rides along the pipeline
   typedef struct packed {
      logic valid;
      logic track_start;
      logic frame_end;
      logic add;          // bin 1 and up: counts toward flux
      logic low;          // also counts toward the low band
   } tag_type;

   typedef struct packed {
      logic [SUM_W-1:0] flux;
      logic [SUM_W-1:0] low_band_flux;
   } result_type;

endpackage

>>> rtl/lsfo_req_if.sv
// ----------------------------------------------------------------------------
// lsfo_req_if: request channel
// Valid/ready channel carrying one spectral bin magnitude per request.
// ----------------------------------------------------------------------------
interface lsfo_req_if
   import lsfo_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;
   logic             track_start;

   modport source (output valid, output magnitude, output track_start, input ready);
   modport sink   (input valid, input magnitude, input track_start, output ready);
endinterface

>>> rtl/lsfo_rsp_if.sv
// ----------------------------------------------------------------------------
// lsfo_rsp_if: result channel
// Valid/ready channel carrying the flux sums of one frame.
// ----------------------------------------------------------------------------
interface lsfo_rsp_if
   import lsfo_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] flux;
   logic [SUM_W-1:0] low_band_flux;

   modport source (output valid, output flux, output low_band_flux, input ready);
   modport sink   (input valid, input flux, input low_band_flux, output ready);
endinterface

>>> rtl/lsfo_csr_if.sv
// ----------------------------------------------------------------------------
// lsfo_csr_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lsfo_csr_if
   import lsfo_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/lsfo_front.sv
// ----------------------------------------------------------------------------
// lsfo_front: configuration registers, bin counter and input register
// Tags every accepted request with its bin, frame end and band membership.
// ----------------------------------------------------------------------------
module lsfo_front
   import lsfo_pkg::*;
#(
   parameter  int MAX_BINS = MAX_BINS_DEF,
   localparam int BIN_W    = $clog2(MAX_BINS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   lsfo_req_if.sink         req,
   lsfo_csr_if.sink         csr,
   output logic [MAG_W-1:0] mag,
   output tag_type          tag,
   output logic [BIN_W-1:0] bin
);

   localparam logic [CFG_W-1:0] MIN_BINS = CFG_W'(2);
   localparam logic [CFG_W:0]   MAX_LAST = (CFG_W+1)'(MAX_BINS - 1);
   localparam logic [CFG_W:0]   MAX_NB   = (CFG_W+1)'(MAX_BINS);

   logic [CFG_W-1:0] num_bins_ff;
   logic [CFG_W-1:0] low_bin_end_ff;
   logic [BIN_W-1:0] bin_cnt_ff, bin_cnt_in;
   logic [MAG_W-1:0] mag_ff;
   tag_type          tag_ff, tag_in;
   logic [BIN_W-1:0] bin_ff;
   logic [BIN_W-1:0] cur_bin;
   logic [CFG_W:0]   last_bin;
   logic             accept;

   assign req.ready = advance;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bins_ff    <= NUM_BINS_RST;
         low_bin_end_ff <= LOW_BIN_END_RST;
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            CSR_NUM_BINS:    num_bins_ff    <= csr.data;
            CSR_LOW_BIN_END: low_bin_end_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // Clamp the frame length to [2, MAX_BINS]
   always_comb begin
      priority if (num_bins_ff < MIN_BINS) begin
         last_bin = (CFG_W+1)'(1);
      end else if ({1'b0, num_bins_ff} > MAX_NB) begin
         last_bin = MAX_LAST;
      end else begin
         last_bin = {1'b0, num_bins_ff} - (CFG_W+1)'(1);
      end
   end

   always_comb begin
      cur_bin            = req.track_start ? '0 : bin_cnt_ff;
      tag_in.valid       = req.valid;
      tag_in.track_start = req.track_start;
      tag_in.frame_end   = (CFG_W+1)'(cur_bin) >= last_bin;
      tag_in.add         = cur_bin != '0;
      tag_in.low         = (cur_bin != '0) && ((CFG_W+1)'(cur_bin) < {1'b0, low_bin_end_ff});
      bin_cnt_in         = tag_in.frame_end ? '0 : cur_bin + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_cnt_ff <= '0;
         tag_ff     <= '0;
      end else if (advance) begin
         tag_ff <= tag_in;
         if (accept) begin
            bin_cnt_ff <= bin_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff <= req.magnitude;
         bin_ff <= cur_bin;
      end
   end

   assign mag = mag_ff;
   assign tag = tag_ff;
   assign bin = bin_ff;

endmodule

>>> rtl/lsfo_log.sv
// ----------------------------------------------------------------------------
// lsfo_log: pipelined log1p(10*m) compressor
// Normalizes 1 + 10*m, extracts 16 log2 fraction bits by repeated squaring,
// one round per stage, and scales by ln 2 into Q4.12.
// ----------------------------------------------------------------------------
module lsfo_log
   import lsfo_pkg::*;
#(
   parameter  int MAX_BINS = MAX_BINS_DEF,
   localparam int BIN_W    = $clog2(MAX_BINS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [MAG_W-1:0] mag,
   input  tag_type          tag,
   input  logic [BIN_W-1:0] bin,
   output logic [LOG_W-1:0] lm,
   output tag_type          lm_tag,
   output logic [BIN_W-1:0] lm_bin
);

   localparam int              L_W    = EXP_W + FRAC_W;
   localparam int              PROD_W = L_W + LN2_W;
   localparam int              SCL_W  = PROD_W - ROUND_SH;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (ROUND_SH - 1);

   // 1 + 10*m
   logic [V_W-1:0]   v_in, v_ff;
   tag_type          v_tag_ff;
   logic [BIN_W-1:0] v_bin_ff;

   assign v_in = V_ONE + (V_W'(mag) << 3) + (V_W'(mag) << 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_tag_ff <= '0;
      end else if (advance) begin
         v_tag_ff <= tag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         v_ff     <= v_in;
         v_bin_ff <= bin;
      end
   end

   // Normalize: leading one to bit Z_W-1
   logic [EXP_W-1:0] lead;
   logic [Z_W-1:0]   z_norm;

   always_comb begin
      lead = '0;
      for (int k = 0; k < V_W; k++) begin
         if (v_ff[k]) begin
            lead = EXP_W'(k);
         end
      end
   end

   assign z_norm = Z_W'(v_ff) << (EXP_W'(Z_W - 1) - lead);

   // Stage 0 is the normalized value, stage i+1 holds fraction bits 15..15-i
   logic [Z_W-1:0]    z_ff    [FRAC_W+1];
   logic [FRAC_W-1:0] frac_ff [FRAC_W+1];
   logic [EXP_W-1:0]  ex_ff   [FRAC_W+1];
   logic [BIN_W-1:0]  bin_ff  [FRAC_W+1];
   tag_type           tag_ff  [FRAC_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (advance) begin
         tag_ff[0] <= v_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z_ff[0]    <= z_norm;
         frac_ff[0] <= '0;
         ex_ff[0]   <= lead;
         bin_ff[0]  <= v_bin_ff;
      end
   end

   for (genvar i = 0; i < FRAC_W; i++) begin : g_sq
      logic [2*Z_W-1:0]  sq;
      logic [Z_W:0]      top;
      logic [FRAC_W-1:0] frac_in;
      logic [Z_W-1:0]    z_in;

      // Square in Q1.30; a result of 2.0 or more sets the bit and halves
      always_comb begin
         sq                    = (2*Z_W)'(z_ff[i]) * (2*Z_W)'(z_ff[i]);
         top                   = sq[2*Z_W-1:Z_W-1];
         frac_in               = frac_ff[i];
         frac_in[FRAC_W-1-i]   = top[Z_W];
         z_in                  = top[Z_W] ? top[Z_W:1] : top[Z_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i+1] <= '0;
         end else if (advance) begin
            tag_ff[i+1] <= tag_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            z_ff[i+1]    <= z_in;
            frac_ff[i+1] <= frac_in;
            ex_ff[i+1]   <= ex_ff[i];
            bin_ff[i+1]  <= bin_ff[i];
         end
      end
   end

   // Scale log2 by ln 2, round to Q4.12
   logic [L_W-1:0]    l_val;
   logic [PROD_W-1:0] prod;
   logic [SCL_W-1:0]  scaled;
   logic [LOG_W-1:0]  lm_in, lm_ff;
   tag_type           lm_tag_ff;
   logic [BIN_W-1:0]  lm_bin_ff;

   always_comb begin
      l_val  = {ex_ff[FRAC_W] - EXP_BIAS, frac_ff[FRAC_W]};
      prod   = PROD_W'(l_val) * PROD_W'(LN2_Q16) + HALF;
      scaled = prod[PROD_W-1:ROUND_SH];
      lm_in  = (scaled[SCL_W-1:LOG_W] != '0) ? '1 : scaled[LOG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lm_tag_ff <= '0;
      end else if (advance) begin
         lm_tag_ff <= tag_ff[FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lm_ff     <= lm_in;
         lm_bin_ff <= bin_ff[FRAC_W];
      end
   end

   assign lm     = lm_ff;
   assign lm_tag = lm_tag_ff;
   assign lm_bin = lm_bin_ff;

endmodule

>>> rtl/lsfo_accum.sv
// ----------------------------------------------------------------------------
// lsfo_accum: previous-frame store and flux accumulation
// Reads the previous frame's compressed value of the bin, adds positive
// increases into the saturating sums and writes the new value back.
// ----------------------------------------------------------------------------
module lsfo_accum
   import lsfo_pkg::*;
#(
   parameter  int MAX_BINS = MAX_BINS_DEF,
   localparam int BIN_W    = $clog2(MAX_BINS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [LOG_W-1:0] lm,
   input  tag_type          lm_tag,
   input  logic [BIN_W-1:0] lm_bin,
   output logic             push,
   output result_type       result
);

   logic [LOG_W-1:0] mem [MAX_BINS];

   logic [LOG_W-1:0] prev_rd_ff;
   logic             hit_ff;
   logic [LOG_W-1:0] lm_a_ff;
   logic [BIN_W-1:0] bin_a_ff;
   tag_type          tag_a_ff;

   // Bins are written in counting order, so the written entries are always
   // the prefix below fill_ff; entries at or above it still read as zero.
   logic [BIN_W:0]   fill_ff, fill_in;

   logic [SUM_W-1:0] flux_ff, flux_in;
   logic [SUM_W-1:0] low_ff, low_in;
   logic             first_ff, first_in;

   logic [LOG_W-1:0] prev, rise;
   logic [SUM_W-1:0] base_flux, base_low, flux_new, low_new;
   logic [SUM_W:0]   flux_sum, low_sum;
   logic             first_now;
   logic             write_en;

   assign write_en = advance && tag_a_ff.valid;

   always_ff @(posedge clock) begin
      if (advance) begin
         prev_rd_ff <= mem[lm_bin];
         if (tag_a_ff.valid) begin
            mem[bin_a_ff] <= lm_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff   <= {1'b0, lm_bin} < fill_ff;
         lm_a_ff  <= lm;
         bin_a_ff <= lm_bin;
      end
   end

   always_comb begin
      prev      = hit_ff ? prev_rd_ff : '0;
      rise      = (lm_a_ff > prev) ? lm_a_ff - prev : '0;
      base_flux = tag_a_ff.track_start ? '0 : flux_ff;
      base_low  = tag_a_ff.track_start ? '0 : low_ff;
      first_now = tag_a_ff.track_start | first_ff;
      flux_sum  = {1'b0, base_flux} + (SUM_W+1)'(tag_a_ff.add ? rise : '0);
      low_sum   = {1'b0, base_low} + (SUM_W+1)'(tag_a_ff.low ? rise : '0);
      flux_new  = flux_sum[SUM_W] ? SUM_MAX : flux_sum[SUM_W-1:0];
      low_new   = low_sum[SUM_W] ? SUM_MAX : low_sum[SUM_W-1:0];

      push                 = write_en && tag_a_ff.frame_end;
      result.flux          = first_now ? '0 : flux_new;
      result.low_band_flux = first_now ? '0 : low_new;

      flux_in  = flux_ff;
      low_in   = low_ff;
      first_in = first_ff;
      fill_in  = fill_ff;
      if (write_en) begin
         if (tag_a_ff.frame_end) begin
            flux_in  = '0;
            low_in   = '0;
            first_in = 1'b0;
         end else begin
            flux_in  = flux_new;
            low_in   = low_new;
            first_in = first_now;
         end
         if ({1'b0, bin_a_ff} == fill_ff) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         flux_ff  <= '0;
         low_ff   <= '0;
         first_ff <= 1'b1;
         fill_ff  <= '0;
      end else begin
         if (advance) begin
            tag_a_ff <= lm_tag;
         end
         flux_ff  <= flux_in;
         low_ff   <= low_in;
         first_ff <= first_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

>>> rtl/lsfo_out_buf.sv
// ----------------------------------------------------------------------------
// lsfo_out_buf: two-entry result buffer
// Holds frame results for the receiver; the pipeline runs while it has room.
// ----------------------------------------------------------------------------
module lsfo_out_buf
   import lsfo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  result_type  push_data,
   output logic        room,
   lsfo_rsp_if.source  rsp
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   result_type       slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign room              = count_ff != CNT_W'(DEPTH);
   assign rsp.valid         = count_ff != '0;
   assign rsp.flux          = slot_ff[rd_ptr_ff].flux;
   assign rsp.low_band_flux = slot_ff[rd_ptr_ff].low_band_flux;
   assign pop               = rsp.valid && rsp.ready;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/log_spectral_flux_onset.sv
// ----------------------------------------------------------------------------
// log_spectral_flux_onset: log spectral flux onset detector
// Streams spectral bin magnitudes and reports per-frame log spectral flux.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  takes one bin magnitude (unsigned Q16.8) per request, bins in
//             order; track_start marks bin 0 of a track's first frame and
//             restarts the bin count, the sums and first-frame handling.
//   rsp_chan  delivers one result per frame, on its last bin: the saturating
//             Q16.12 flux over bins 1 and up and the low-band flux over bins
//             below low_bin_end. The first frame of a track reports zeros.
//   csr_chan  writes num_bins (index 0) and low_bin_end (index 1); always
//             ready. Write only while no request is in flight.
//   Throughput is one request per cycle while the result buffer has room. A
//   result appears on rsp_chan after its last bin is accepted and passes the
//   input register, 1 + 10*m, normalize, 16 squaring stages of the log unit,
//   ln 2 scaling, the previous-frame RAM read, then the result buffer.
//   Reset clears the counter, sums and buffer and restores num_bins = 513,
//   low_bin_end = 4; the previous-frame RAM needs no clearing pass, since a
//   fill mark makes bins not yet written read as zero.
//   A stalled receiver fills the two-entry result buffer; requests keep
//   flowing until both entries are taken, then req_chan.ready drops.
// ----------------------------------------------------------------------------
module log_spectral_flux_onset
   import lsfo_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lsfo_req_if.sink   req_chan,
   lsfo_rsp_if.source rsp_chan,
   lsfo_csr_if.sink   csr_chan
);

   localparam int BIN_W = $clog2(MAX_BINS);

   // Whole pipeline moves together while the result buffer has room
   logic             advance;
   logic [MAG_W-1:0] mag;
   tag_type          tag;
   logic [BIN_W-1:0] bin;
   logic [LOG_W-1:0] lm;
   tag_type          lm_tag;
   logic [BIN_W-1:0] lm_bin;
   logic             push;
   result_type       result;

   // Count bins, hold config, register the request
   lsfo_front #(
      .MAX_BINS (MAX_BINS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_chan),
      .csr     (csr_chan),
      .mag     (mag),
      .tag     (tag),
      .bin     (bin)
   );

   // Compress to log1p(10*m) in Q4.12
   lsfo_log #(
      .MAX_BINS (MAX_BINS)
   ) u_log (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .mag     (mag),
      .tag     (tag),
      .bin     (bin),
      .lm      (lm),
      .lm_tag  (lm_tag),
      .lm_bin  (lm_bin)
   );

   // Compare with the previous frame, accumulate, write back
   lsfo_accum #(
      .MAX_BINS (MAX_BINS)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .lm      (lm),
      .lm_tag  (lm_tag),
      .lm_bin  (lm_bin),
      .push    (push),
      .result  (result)
   );

   // Buffer frame results toward the receiver
   lsfo_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .room      (advance),
      .rsp       (rsp_chan)
   );

endmodule

>>> rtl/lsfo_checker.sv
// ----------------------------------------------------------------------------
// lsfo_checker: port-level assertions for log_spectral_flux_onset
// Checks reset behavior, backpressure, result holding and result values.
// ----------------------------------------------------------------------------
module lsfo_checker
   import lsfo_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [SUM_W-1:0] flux,
   input logic [SUM_W-1:0] low_band_flux
);

   logic seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= 1'b1;
      end
   end

   // Leave reset with an empty buffer and open input
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid && req_ready)
      else $error("lsfo: not empty and ready after reset");

   // Backpressure only comes from results waiting
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("lsfo: request stalled with no result pending");

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(flux) && $stable(low_band_flux))
      else $error("lsfo: stalled result changed");

   // Low band is a subset of the full flux
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> low_band_flux <= flux)
      else $error("lsfo: low-band flux exceeds flux");

   // The first result after reset belongs to a first frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !seen_ff |-> flux == '0 && low_band_flux == '0)
      else $error("lsfo: first frame result not zero");

endmodule

bind log_spectral_flux_onset lsfo_checker u_lsfo_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .flux          (rsp_chan.flux),
   .low_band_flux (rsp_chan.low_band_flux)
);

>>> sim/log_spectral_flux_onset_checker.sv
// ----------------------------------------------------------------------------
// log_spectral_flux_onset_checker: result predictor and scoreboard
// Watches the request, result and register channels, predicts the flux of
// each frame from the accepted bins and compares every result against it.
// ----------------------------------------------------------------------------
module log_spectral_flux_onset_checker
   import lsfo_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEF
) (
   input  logic clock,
   input  logic reset,
   lsfo_req_if  req_chan,
   lsfo_rsp_if  rsp_chan,
   lsfo_csr_if  csr_chan,
   output int   mismatch_count,
   output int   frames_pending
);

   logic [LOG_W-1:0] prior_log_mag [MAX_BINS];
   int unsigned      bin_pos;
   logic [SUM_W-1:0] flux_acc;
   logic [SUM_W-1:0] low_acc;
   logic             first_frame;
   logic [CFG_W-1:0] cfg_num_bins;
   logic [CFG_W-1:0] cfg_low_bin_end;
   result_type       frame_flux_queue [$];

   initial begin
      mismatch_count = 0;
      frames_pending = 0;
   end

   // ln(1 + 10*m) in Q4.12 through a squaring log2 and a ln 2 scale
   function automatic logic [LOG_W-1:0] log_compress(input logic [MAG_W-1:0] mag);
      logic [63:0]  v;
      logic [63:0]  z;
      logic [63:0]  log2_q16;
      logic [63:0]  ln_q12;
      logic [15:0]  frac;
      int unsigned  lead;
      int           i;
      v    = 64'd256 + 64'd10 * 64'(mag);
      lead = 0;
      while (lead < 63 && (v >> (lead + 1)) != 0) lead++;
      z    = v << (30 - lead);
      frac = '0;
      for (i = 0; i < 16; i++) begin
         z = (z * z) >> 30;
         if (z >= (64'd2 << 30)) begin
            frac[15 - i] = 1'b1;
            z = z >> 1;
         end
      end
      log2_q16 = (64'(lead - 8) << 16) | 64'(frac);
      ln_q12   = (log2_q16 * 64'(LN2_Q16) + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
      return (ln_q12 > 64'hFFFF) ? 16'hFFFF : ln_q12[15:0];
   endfunction

   function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                               input logic [LOG_W-1:0] rise);
      logic [SUM_W:0] total;
      total = {1'b0, acc} + (SUM_W + 1)'(rise);
      return (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: flux mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Advance the bin position by one accepted request
   task automatic predict_bin(input logic [MAG_W-1:0] mag, input logic track_start);
      int unsigned      frame_len;
      int unsigned      b;
      logic [LOG_W-1:0] cur;
      logic [LOG_W-1:0] prv;
      result_type       res;
      frame_len = cfg_num_bins;
      if (frame_len < 2) frame_len = 2;
      if (frame_len > MAX_BINS) frame_len = MAX_BINS;
      if (track_start) begin
         bin_pos     = 0;
         flux_acc    = '0;
         low_acc     = '0;
         first_frame = 1'b1;
      end
      b = (bin_pos >= MAX_BINS) ? MAX_BINS - 1 : bin_pos;
      cur = log_compress(mag);
      prv = prior_log_mag[b];
      if (b >= 1 && cur > prv) begin
         flux_acc = sat_sum(flux_acc, cur - prv);
         if (b < cfg_low_bin_end) low_acc = sat_sum(low_acc, cur - prv);
      end
      prior_log_mag[b] = cur;
      if (b >= frame_len - 1) begin
         if (first_frame) begin
            res.flux          = '0;
            res.low_band_flux = '0;
            first_frame       = 1'b0;
         end else begin
            res.flux          = flux_acc;
            res.low_band_flux = low_acc;
         end
         frame_flux_queue = {frame_flux_queue, res};
         flux_acc = '0;
         low_acc  = '0;
         bin_pos  = 0;
      end else begin
         bin_pos = b + 1;
      end
   endtask

   task automatic check_frame();
      result_type want;
      if (frame_flux_queue.size() == 0) begin
         report_mismatch($sformatf("unexpected result flux=%0h low=%0h",
                                   rsp_chan.flux, rsp_chan.low_band_flux));
      end else begin
         want = frame_flux_queue.pop_front();
         if (rsp_chan.flux !== want.flux)
            report_mismatch($sformatf("flux got %0h want %0h", rsp_chan.flux, want.flux));
         if (rsp_chan.low_band_flux !== want.low_band_flux)
            report_mismatch($sformatf("low_band_flux got %0h want %0h",
                                      rsp_chan.low_band_flux, want.low_band_flux));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BINS; i++) prior_log_mag[i] = '0;
         bin_pos         = 0;
         flux_acc        = '0;
         low_acc         = '0;
         first_frame     = 1'b1;
         cfg_num_bins    = NUM_BINS_RST;
         cfg_low_bin_end = LOW_BIN_END_RST;
         frame_flux_queue.delete();
      end else begin
         if (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1) begin
            case (csr_chan.index)
               CSR_NUM_BINS:    cfg_num_bins    = csr_chan.data;
               CSR_LOW_BIN_END: cfg_low_bin_end = csr_chan.data;
               default: ;
            endcase
         end
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) check_frame();
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            predict_bin(req_chan.magnitude, req_chan.track_start);
      end
      frames_pending = frame_flux_queue.size();
   end

endmodule

>>> sim/log_spectral_flux_onset_tb.sv
// ----------------------------------------------------------------------------
// log_spectral_flux_onset_tb: testbench top of the log spectral flux onset block
// Streams directed and random bin requests through several register settings,
// with random gaps and result stalls; a checker beside the block predicts
// and compares every frame result.
// ----------------------------------------------------------------------------
module log_spectral_flux_onset_tb;
   import lsfo_pkg::*;

   localparam int MAX_BINS      = MAX_BINS_DEF;
   localparam int RANDOM_BINS   = 1400;  // random requests to send
   localparam int LATENCY_GUARD = 32;    // settle margin beyond the block pipeline
   localparam int IDLE_LIMIT    = 3000;  // cycles without any handshake
   localparam int DIRECTED_LEN  = 21;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   frames_pending;
   bit   req_steady;
   int   idle_cycles;

   lsfo_req_if req_chan ();
   lsfo_rsp_if rsp_chan ();
   lsfo_csr_if csr_chan ();

   // Directed frames of four bins, low band = bins 1 and 2
   logic [MAG_W-1:0] directed_mag [DIRECTED_LEN] = '{
      24'h000000, 24'hFFFFFF, 24'h000001, 24'h000000,   // first frame: zeros
      24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,   // rises, bin zero ignored
      24'h000000, 24'h000000, 24'h000100, 24'hAAAAAA,   // falls and one rise
      24'h000005, 24'h555555, 24'hFFFFFF, 24'h000003,   // track restart mid-frame
      24'h0000FF, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
      24'hFFFFFF
   };
   logic directed_start [DIRECTED_LEN] = '{
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
   };

   log_spectral_flux_onset #(
      .MAX_BINS (MAX_BINS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   log_spectral_flux_onset_checker #(
      .MAX_BINS (MAX_BINS)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .mismatch_count (mismatch_count),
      .frames_pending (frames_pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly no gap, some short ones, a few long ones; none in steady phases
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (req_steady || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic int pick_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Mix full-range, small, extreme, power-of-two and shifted magnitudes
   function automatic logic [MAG_W-1:0] random_magnitude();
      logic [MAG_W-1:0] m;
      case ($urandom_range(0, 4))
         0: m = MAG_W'($urandom_range(0, 24'hFFFFFF));
         1: m = MAG_W'($urandom_range(0, 255));
         2: m = ($urandom_range(0, 1) == 1) ? '1 : '0;
         3: begin
            m = MAG_W'(1) << $urandom_range(0, MAG_W - 1);
            if ($urandom_range(0, 1) == 1) m = m - 1'b1;
         end
         default: m = MAG_W'($urandom_range(0, 16'hFFFF)) << $urandom_range(0, 8);
      endcase
      return m;
   endfunction

   // Offer one bin request and hold it until the block takes it
   task automatic send_bin(input logic [MAG_W-1:0] mag, input logic track_start);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.magnitude   <= mag;
      req_chan.track_start <= track_start;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (csr_chan.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Drop the request, wait out every pending frame, then let the pipe settle
   task automatic wait_for_results(input int settle);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (frames_pending != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Result side: ready runs broken by random stalls, with steady stretches
   initial begin : result_ready_driver
      int stall;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(0, 20)) @(negedge clock);
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(80, 200)) @(negedge clock);
         stall = pick_stall();
         if (stall > 0) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   // End the run when no channel moves for too long
   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("** log_spectral_flux_onset: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int          bins_sent;
      int          phase;
      int          frame_len;
      int          eff_len;
      int          low_end;
      int          count;
      int          slot;
      logic        start;

      // Drive every input to a known value and hold reset
      reset                = 1'b1;
      req_steady           = 1'b0;
      req_chan.valid       = 1'b0;
      req_chan.magnitude   = '0;
      req_chan.track_start = 1'b0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = CSR_NUM_BINS;
      csr_chan.data        = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed frames: extremes, bin zero, first frame, track restart
      write_register(CSR_NUM_BINS, CFG_W'(4));
      write_register(CSR_LOW_BIN_END, CFG_W'(3));
      for (int i = 0; i < DIRECTED_LEN; i++) send_bin(directed_mag[i], directed_start[i]);

      // Random phases, each under its own register setting
      bins_sent = 0;
      phase     = 0;
      slot      = 0;
      while (bins_sent < RANDOM_BINS) begin
         case (phase)
            0: begin frame_len = MAX_BINS; low_end = MAX_BINS; count = 180; end
            1: begin frame_len = 8191;     low_end = 8191;     count = 120; end
            2: begin frame_len = 0;        low_end = 0;        count = 60;  end
            3: begin frame_len = 1;        low_end = 1;        count = 60;  end
            4: begin frame_len = 2;        low_end = 2;        count = 60;  end
            default: begin
               frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200)
                                                       : $urandom_range(2, 24);
               case ($urandom_range(0, 7))
                  0: low_end = 0;
                  1: low_end = 1;
                  2: low_end = MAX_BINS;
                  3: low_end = 8191;
                  default: low_end = $urandom_range(0, frame_len + 1);
               endcase
               count = $urandom_range(40, 110);
            end
         endcase
         eff_len = (frame_len < 2) ? 2 : (frame_len > MAX_BINS) ? MAX_BINS : frame_len;

         // Write only while the block is idle; a lower count ends the open frame
         wait_for_results(LATENCY_GUARD);
         write_register(CSR_NUM_BINS, CFG_W'(frame_len));
         write_register(CSR_LOW_BIN_END, CFG_W'(low_end));
         req_steady = ($urandom_range(0, 3) == 0);

         repeat (count) begin
            // Start tracks mostly on a frame boundary, rarely anywhere
            start = (slot == 0 && $urandom_range(0, 5) == 0) || ($urandom_range(0, 60) == 0);
            send_bin(random_magnitude(), start);
            slot = start ? 1 : slot + 1;
            if (slot >= eff_len) slot = 0;
            bins_sent++;
            // Hold off now and then until every frame result is back
            if ($urandom_range(0, 199) == 0) wait_for_results(0);
         end
         phase++;
      end

      wait_for_results(LATENCY_GUARD + 8);
      if (mismatch_count == 0 && frames_pending == 0)
         $display("** log_spectral_flux_onset: PASSED **");
      else
         $display("** log_spectral_flux_onset: FAILED **");
      $finish;
   end

endmodule
